// ===== rtl/unordered_array_table_unit_macros.svh =====
// Assertion macros shared by the unordered array table checker.
`ifndef UNORDERED_ARRAY_TABLE_UNIT_MACROS_SVH
`define UNORDERED_ARRAY_TABLE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define UAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uat: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define UAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uat: next-cycle check failed");

`endif

// ===== rtl/uat_pkg.sv =====
// Shared widths, codes and result type of the unordered array table.
`timescale 1ns / 1ps
package uat_pkg;

  localparam int unsigned CapacityDefault = 256;
  localparam int unsigned KindW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned CountW  = 9;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND     = 3'd0,
    KIND_REMOVE_POS = 3'd1,
    KIND_REMOVE_VAL = 3'd2,
    KIND_FIND       = 3'd3,
    KIND_READ       = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_RANGE   = 2'd2,
    STATUS_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    status_e                   status;
    logic [IndexW-1:0]         index;
    logic signed [DataW-1:0]   data;
    logic [CountW-1:0]         count;
  } uat_res_t;

endpackage

// ===== rtl/uat_if.sv =====
// Request and response channel interfaces of the unordered array table.
`timescale 1ns / 1ps
interface uat_in_if;
  import uat_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KindW-1:0]        kind;
  logic signed [DataW-1:0] value;
  logic [PosW-1:0]         position;

  modport source (output valid, kind, value, position, input ready);
  modport sink (input valid, kind, value, position, output ready);
endinterface

interface uat_out_if;
  import uat_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic [IndexW-1:0]       index;
  logic signed [DataW-1:0] data;
  logic [CountW-1:0]       count;

  modport source (output valid, status, index, data, count, input ready);
  modport sink (input valid, status, index, data, count, output ready);
endinterface

// ===== rtl/unordered_array_table_unit.sv =====
// Unordered array table: fixed-capacity word store with swap-remove and linear search.
//
//   channel | dir | beat contents
//   in_i    | in  | kind, value, position
//   out_o   | out | status, index, data, count
//
// Append, clear, unused kinds and rejected requests go straight to the response state.
// Read and remove at position first take one synchronous memory read.
// Find and remove by value scan upward from entry 0; the single
// memory read port scans one entry per cycle, so a miss walks all entries.
// Reset clears the count, state and output valid; stored words are not cleared.
// A result waits in the output register while the next item is accepted;
// a further result holds in the response state until that register frees.
`timescale 1ns / 1ps
module unordered_array_table_unit #(
  parameter int unsigned Capacity = uat_pkg::CapacityDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  uat_in_if.sink    in_i,
  uat_out_if.source out_o
);
  import uat_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_MOVE,
    ST_RESP
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  kind_e                   kind_q, kind_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  uat_res_t                res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  uat_res_t                out_res_q, out_res_d;

  logic signed [DataW-1:0] mem_q [Capacity];
  logic signed [DataW-1:0] rdata_q;
  logic                    mem_we, mem_re;
  logic [AddrW-1:0]        mem_waddr, mem_raddr;
  logic signed [DataW-1:0] mem_wdata;

  logic  pos_ok;
  kind_e in_kind;

  assign in_kind = kind_e'(in_i.kind);
  assign pos_ok  = CmpW'(in_i.position) < CmpW'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    key_d       = key_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          kind_d  = in_kind;
          key_d   = in_i.value;
          res_d   = '{status: STATUS_OK, index: '0, data: '0, count: CountW'(cnt_q)};
          state_d = ST_RESP;
          case (in_kind)
            KIND_APPEND: begin
              if (cnt_q == CntW'(Capacity)) begin
                res_d.status = STATUS_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = AddrW'(cnt_q);
                mem_wdata   = in_i.value;
                cnt_d       = cnt_q + 1'b1;
                res_d.index = IndexW'(cnt_q);
                res_d.count = CountW'(cnt_q + 1'b1);
              end
            end
            KIND_REMOVE_POS: begin
              if (!pos_ok) begin
                res_d.status = STATUS_RANGE;
              end else begin
                // fetch the last entry; it fills the hole next cycle
                mem_re      = 1'b1;
                mem_raddr   = AddrW'(cnt_q - 1'b1);
                idx_d       = AddrW'(in_i.position);
                res_d.index = in_i.position;
                state_d     = ST_MOVE;
              end
            end
            KIND_REMOVE_VAL, KIND_FIND: begin
              if (cnt_q == '0) begin
                res_d.status = STATUS_MISSING;
              end else begin
                mem_re  = 1'b1;
                idx_d   = '0;
                state_d = ST_SCAN;
              end
            end
            KIND_READ: begin
              if (!pos_ok) begin
                res_d.status = STATUS_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AddrW'(in_i.position);
                state_d   = ST_READ;
              end
            end
            KIND_CLEAR: begin
              cnt_d       = '0;
              res_d.count = '0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        res_d.data = rdata_q;
        state_d    = ST_RESP;
      end
      ST_SCAN: begin
        // rdata_q holds entry idx_q; on a mismatch with entries left the next entry is fetched
        if (rdata_q == key_q) begin
          res_d.index = IndexW'(idx_q);
          if (kind_q == KIND_REMOVE_VAL) begin
            mem_re    = 1'b1;
            mem_raddr = AddrW'(cnt_q - 1'b1);
            state_d   = ST_MOVE;
          end else begin
            state_d = ST_RESP;
          end
        end else if (CntW'(idx_q) + 1'b1 == cnt_q) begin
          res_d.status = STATUS_MISSING;
          state_d      = ST_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_q + 1'b1;
          idx_d     = idx_q + 1'b1;
        end
      end
      ST_MOVE: begin
        mem_we      = 1'b1;
        mem_waddr   = idx_q;
        mem_wdata   = rdata_q;
        cnt_d       = cnt_q - 1'b1;
        res_d.count = CountW'(cnt_q - 1'b1);
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      key_q       <= key_d;
      idx_q       <= idx_d;
      res_q       <= res_d;
      out_res_q   <= out_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_res_q.status;
  assign out_o.index  = out_res_q.index;
  assign out_o.data   = out_res_q.data;
  assign out_o.count  = out_res_q.count;

endmodule

// ===== rtl/uat_checker.sv =====
// Port-level assertions for the unordered array table, bound to the top level.
`timescale 1ns / 1ps
`include "unordered_array_table_unit_macros.svh"
module uat_checker #(
  parameter int unsigned Capacity = uat_pkg::CapacityDefault
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [uat_pkg::StatusW-1:0]     status_i,
  input logic [uat_pkg::IndexW-1:0]      index_i,
  input logic signed [uat_pkg::DataW-1:0] data_i,
  input logic [uat_pkg::CountW-1:0]      count_i
);
  import uat_pkg::*;

  // a stalled beat keeps its contents
  `UAT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(status_i) && $stable(index_i) && $stable(data_i) && $stable(count_i))

  // one item in flight: ready drops right after an accepted beat
  `UAT_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  `UAT_ASSERT_SAME(a_full_count, clk_i, rst_ni, out_valid_i && status_i == STATUS_FULL, count_i == CountW'(Capacity) && index_i == '0 && data_i == '0)

  `UAT_ASSERT_SAME(a_fail_zero, clk_i, rst_ni, out_valid_i && (status_i == STATUS_RANGE || status_i == STATUS_MISSING), index_i == '0 && data_i == '0)

  `UAT_ASSERT_SAME(a_count_cap, clk_i, rst_ni, out_valid_i, 32'(count_i) <= Capacity)

endmodule

bind unordered_array_table_unit uat_checker #(
  .Capacity(Capacity)
) u_uat_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .status_i   (out_o.status),
  .index_i    (out_o.index),
  .data_i     (out_o.data),
  .count_i    (out_o.count)
);

// ===== sim/tb_unordered_array_table_unit.sv =====
// Testbench for the unordered array table: random and directed ops checked against a local table.
`timescale 1ns / 1ps
module tb_unordered_array_table_unit;
  import uat_pkg::*;

  localparam int unsigned Capacity   = CapacityDefault;
  localparam int unsigned StopItems  = 1175;
  localparam int unsigned EndSlack   = Capacity + 8;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned PlanCopy   = 0;
  localparam int unsigned LiveCopy   = 1;
  // kind codes the block has no operation for
  localparam logic [KindW-1:0] KindSpare0 = 3'd6;
  localparam logic [KindW-1:0] KindSpare1 = 3'd7;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic signed [DataW-1:0] value;
    logic [PosW-1:0]         position;
  } req_t;

  typedef struct packed {
    logic hold;
    req_t rq;
  } pending_t;

  logic clk_i;
  logic rst_ni;

  uat_in_if  req_if ();
  uat_out_if rsp_if ();

  unordered_array_table_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // two copies of the table: one steers stimulus planning, one tracks accepted beats
  logic signed [DataW-1:0] tbl_word [2][Capacity];
  int unsigned             tbl_used [2];

  pending_t    req_backlog [$];
  uat_res_t    due_results [$];
  uat_res_t    next_due;
  logic        hold_next;
  int unsigned items_planned;
  int unsigned real_items;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned kind_seen [8];
  int unsigned status_seen [4];
  int unsigned peak_count;
  bit          in_took;
  bit          out_took;
  bit          send_burst;
  bit          recv_burst;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned fills;
  int unsigned k;

  function automatic uat_res_t table_apply(int unsigned c, req_t rq);
    uat_res_t    r;
    int unsigned n;
    int unsigned hit;
    int unsigned i;
    n   = tbl_used[c];
    hit = n;
    r   = '{status: STATUS_OK, index: '0, data: '0, count: '0};
    // first match from entry 0 upward
    for (i = 0; i < n; i++) begin
      if (hit == n && tbl_word[c][i] == rq.value) hit = i;
    end
    case (rq.kind)
      KIND_APPEND: begin
        if (n >= Capacity) begin
          r.status = STATUS_FULL;
        end else begin
          tbl_word[c][n] = rq.value;
          tbl_used[c]    = n + 1;
          r.index        = IndexW'(n);
        end
      end
      KIND_REMOVE_POS: begin
        if (rq.position >= n) begin
          r.status = STATUS_RANGE;
        end else begin
          tbl_word[c][rq.position] = tbl_word[c][n - 1];
          tbl_used[c]              = n - 1;
          r.index                  = rq.position;
        end
      end
      KIND_REMOVE_VAL: begin
        if (hit >= n) begin
          r.status = STATUS_MISSING;
        end else begin
          tbl_word[c][hit] = tbl_word[c][n - 1];
          tbl_used[c]      = n - 1;
          r.index          = IndexW'(hit);
        end
      end
      KIND_FIND: begin
        if (hit >= n) r.status = STATUS_MISSING;
        else r.index = IndexW'(hit);
      end
      KIND_READ: begin
        if (rq.position >= n) r.status = STATUS_RANGE;
        else r.data = tbl_word[c][rq.position];
      end
      KIND_CLEAR: begin
        tbl_used[c] = 0;
      end
      default: ;
    endcase
    r.count = CountW'(tbl_used[c]);
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -1;
      3: return 0;
      4, 5, 6: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // mostly a word already stored, so searches hit
  function automatic logic signed [DataW-1:0] pick_key();
    if (tbl_used[PlanCopy] > 0 && $urandom_range(0, 9) < 7)
      return tbl_word[PlanCopy][$urandom_range(0, tbl_used[PlanCopy] - 1)];
    return pick_word();
  endfunction

  function automatic logic [PosW-1:0] pick_pos();
    if (tbl_used[PlanCopy] > 0 && $urandom_range(0, 4) != 0)
      return PosW'($urandom_range(0, tbl_used[PlanCopy] - 1));
    return PosW'($urandom_range(0, 255));
  endfunction

  task automatic queue_item(logic [KindW-1:0] kd, logic signed [DataW-1:0] v,
                            logic [PosW-1:0] p);
    req_t rq;
    rq = '{kind: kd, value: v, position: p};
    void'(table_apply(PlanCopy, rq));
    req_backlog.push_back('{hold: hold_next, rq: rq});
    hold_next = 1'b0;
    items_planned++;
    if (kd <= KIND_CLEAR) real_items++;
  endtask

  task automatic plan_fill();
    int unsigned j;
    while (tbl_used[PlanCopy] < Capacity) queue_item(KIND_APPEND, pick_word(), pick_pos());
    for (j = 0; j < 4; j++) queue_item(KIND_APPEND, pick_word(), pick_pos());
    queue_item(KIND_READ, pick_word(), PosW'(Capacity - 1));
    queue_item(KIND_FIND, pick_key(), pick_pos());
    queue_item(KIND_REMOVE_POS, pick_word(), PosW'(Capacity - 1));
    queue_item(KIND_APPEND, pick_word(), pick_pos());
    queue_item(KIND_REMOVE_POS, pick_word(), '0);
  endtask

  task automatic plan_mixed(int unsigned n, int unsigned grow);
    int unsigned j;
    int unsigned r;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < grow) begin
        queue_item(KIND_APPEND, pick_word(), pick_pos());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 22) queue_item(KIND_REMOVE_POS, pick_word(), pick_pos());
        else if (r < 44) queue_item(KIND_REMOVE_VAL, pick_key(), pick_pos());
        else if (r < 66) queue_item(KIND_FIND, pick_key(), pick_pos());
        else if (r < 92) queue_item(KIND_READ, pick_word(), pick_pos());
        else if (r < 95) queue_item(KIND_CLEAR, pick_word(), pick_pos());
        else if (r < 97)
          queue_item($urandom_range(0, 1) ? KindSpare0 : KindSpare1, pick_word(), pick_pos());
        else queue_item(KIND_APPEND, pick_word(), pick_pos());
      end
    end
  endtask

  task automatic flag_field(string what, logic [DataW-1:0] want, logic [DataW-1:0] got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    fail_count++;
  endtask

  task automatic check_result(uat_res_t got);
    uat_res_t want;
    if (due_results.size() == 0) begin
      $display("%0t: stray result, expected none actual status %0h index %0h data %0h count %0h",
               $time, got.status, got.index, got.data, got.count);
      fail_count++;
    end else begin
      want = due_results.pop_front();
      if (got.status !== want.status)
        flag_field("status", DataW'(want.status), DataW'(got.status));
      if (got.index !== want.index)
        flag_field("index", DataW'(want.index), DataW'(got.index));
      if (got.data !== want.data) flag_field("data", want.data, got.data);
      if (got.count !== want.count)
        flag_field("count", DataW'(want.count), DataW'(got.count));
    end
  endtask

  always #10 clk_i = ~clk_i;

  // request side: per-item gap, holds an item flagged for a full drain
  always @(negedge clk_i) begin
    if (rst_ni && !(req_if.valid && !in_took)) begin
      if (send_wait > 0) begin
        send_wait = send_wait - 1;
        req_if.valid <= 1'b0;
      end else if (req_backlog.size() > 0 &&
                   !(req_backlog[0].hold && due_results.size() > 0)) begin
        req_if.kind     <= req_backlog[0].rq.kind;
        req_if.value    <= req_backlog[0].rq.value;
        req_if.position <= req_backlog[0].rq.position;
        req_if.valid    <= 1'b1;
        void'(req_backlog.pop_front());
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_wait = send_burst ? 0 : $urandom_range(0, 7);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response side: random stall after each beat
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 7);
      end
      if (recv_wait > 0) begin
        recv_wait = recv_wait - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took  = req_if.valid && req_if.ready;
      out_took = rsp_if.valid && rsp_if.ready;
      if (in_took) begin
        next_due = table_apply(LiveCopy, '{kind: req_if.kind, value: req_if.value,
                                           position: req_if.position});
        due_results.push_back(next_due);
        kind_seen[req_if.kind]++;
        status_seen[next_due.status]++;
        if (next_due.count > peak_count) peak_count = 32'(next_due.count);
        items_accepted++;
      end
      if (out_took) begin
        check_result({rsp_if.status, rsp_if.index, rsp_if.data, rsp_if.count});
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = KIND_APPEND;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
    tbl_used[PlanCopy] = 0;
    tbl_used[LiveCopy] = 0;
    hold_next = 1'b0;

    // empty table: every lookup misses or is out of range
    queue_item(KIND_READ, 0, '0);
    queue_item(KIND_REMOVE_POS, 0, '0);
    queue_item(KIND_REMOVE_VAL, 0, 8'hFF);
    queue_item(KIND_FIND, 0, '0);
    queue_item(KIND_APPEND, 32'sh7FFF_FFFF, 8'hFF);
    queue_item(KIND_APPEND, 32'sh8000_0000, '0);
    queue_item(KIND_APPEND, 0, '0);
    queue_item(KIND_APPEND, -1, '0);
    queue_item(KIND_APPEND, 32'sh8000_0000, '0);
    queue_item(KIND_FIND, 32'sh8000_0000, '0);
    queue_item(KIND_FIND, 12345, '0);
    queue_item(KIND_READ, 0, 8'd3);
    queue_item(KIND_READ, 0, 8'hFF);
    queue_item(KIND_READ, 0, 8'd5);
    // swap-remove: last entry moves into the hole
    queue_item(KIND_REMOVE_POS, 0, '0);
    queue_item(KIND_REMOVE_VAL, 32'sh8000_0000, '0);
    queue_item(KIND_REMOVE_VAL, 99, '0);
    queue_item(KIND_REMOVE_POS, 0, 8'd2);
    queue_item(KindSpare0, -1, 8'hFF);
    queue_item(KindSpare1, 32'sh5555_AAAA, 8'h55);
    queue_item(KIND_CLEAR, 0, '0);
    queue_item(KIND_READ, 0, '0);
    queue_item(KIND_APPEND, 5, '0);
    queue_item(KIND_READ, 0, '0);

    hold_next = 1'b1;
    plan_fill();
    fills = 1;
    while (real_items < StopItems) begin
      if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
      case ($urandom_range(0, 5))
        0: begin
          if (fills < 2) begin
            plan_fill();
            fills++;
          end else begin
            plan_mixed($urandom_range(20, 60), 50);
          end
        end
        1: begin
          k = 0;
          while (tbl_used[PlanCopy] > 0 && k < 60) begin
            if ($urandom_range(0, 1)) queue_item(KIND_REMOVE_POS, pick_word(), pick_pos());
            else queue_item(KIND_REMOVE_VAL, pick_key(), pick_pos());
            k++;
          end
          queue_item(KIND_REMOVE_POS, pick_word(), pick_pos());
        end
        default: plan_mixed($urandom_range(20, 60), $urandom_range(15, 75));
      endcase
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (items_accepted != items_planned || due_results.size() != 0);
    repeat (EndSlack) @(negedge clk_i);

    $display("run: %0d results checked; append %0d, remove-at %0d, remove-match %0d, find %0d",
             results_checked, kind_seen[KIND_APPEND], kind_seen[KIND_REMOVE_POS],
             kind_seen[KIND_REMOVE_VAL], kind_seen[KIND_FIND]);
    $display("run: read %0d, clear %0d, unused %0d; full %0d, range %0d, miss %0d, peak %0d",
             kind_seen[KIND_READ], kind_seen[KIND_CLEAR], kind_seen[KindSpare0] +
             kind_seen[KindSpare1], status_seen[STATUS_FULL], status_seen[STATUS_RANGE],
             status_seen[STATUS_MISSING], peak_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/uat_pkg.sv
rtl/uat_if.sv
rtl/unordered_array_table_unit.sv
rtl/uat_checker.sv
sim/tb_unordered_array_table_unit.sv
